// File: rtl/core/mpfasr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpfasr_pkg;

  // Operation codes carried by in_operation
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  // Register file
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_EN     = 2'd2;

  // Field widths, fixed by the item format
  localparam int unsigned PIN_W   = 8;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned MM_W    = 16;

  // Default number of inactive ticks before release
  localparam logic [COUNT_W-1:0] DEFAULT_RELEASE_TICKS = 8'd8;

  localparam logic [MM_W-1:0] MM_MAX = {MM_W{1'b1}};

  // Per-pin result of one item
  typedef struct packed {
    logic asserted;   // next asserted flag
    logic upd;        // pin changed (or was re-asserted)
    logic mismatch;   // flagged event found the pin inactive
  } lane_res_t;

endpackage

`default_nettype wire

// File: rtl/core/mpfasr_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module mpfasr_lane (
  input  wire logic                          operation,
  input  wire logic                          level,
  input  wire logic                          flagged,
  input  wire logic                          act_hi,
  input  wire logic                          asserted,
  input  wire logic [mpfasr_pkg::COUNT_W-1:0] count,
  input  wire logic [mpfasr_pkg::COUNT_W-1:0] release_ticks,
  output logic      [mpfasr_pkg::COUNT_W-1:0] count_nxt,
  output mpfasr_pkg::lane_res_t              res
);
  import mpfasr_pkg::*;

  logic is_active;

  assign is_active = (level == act_hi);

  always_comb begin
    count_nxt    = count;
    res.asserted = asserted;
    res.upd      = 1'b0;
    res.mismatch = 1'b0;
    case (operation)
      OP_TICK: begin
        if (asserted) begin
          count_nxt = is_active ? '0 : count + COUNT_W'(1);
          // release check uses the freshly updated count
          if (count_nxt == release_ticks) begin
            res.asserted = 1'b0;
            res.upd      = 1'b1;
          end
        end
      end
      default: begin
        if (flagged) begin
          if (is_active) begin
            count_nxt    = '0;
            res.asserted = 1'b1;
            res.upd      = 1'b1;
          end else begin
            res.mismatch = 1'b1;
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/multi_pin_fast_assert_slow_release_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake         | Payload
// --------+-------------------+--------------------------------------------------
// in      | in_valid/in_stall | in_operation, in_pin_levels, in_event_pins
// out     | out_valid/out_stall | out_level_mask, out_mismatch_count
// cfg     | APB (psel..pready) | active_levels, release_ticks, reporting_enabled
//
// One item per cycle sustained while no result waits under out_stall. An accepted
// item is held in the input register, then its pin updates are computed in one
// pass and the result (if any) lands in the output register.
// Reset is synchronous (rst_n low): all pins deasserted, counts and the
// mismatch total cleared, registers back to their defaults.
// in_stall rises only when the input register holds an item while a result
// waits under out_stall; the input register and output register decouple sides.

module multi_pin_fast_assert_slow_release_top #(
  parameter int unsigned NUM_PINS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_operation,
  input  wire logic [mpfasr_pkg::PIN_W-1:0]        in_pin_levels,
  input  wire logic [mpfasr_pkg::PIN_W-1:0]        in_event_pins,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [mpfasr_pkg::PIN_W-1:0]        out_level_mask,
  output logic      [mpfasr_pkg::MM_W-1:0]         out_mismatch_count,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mpfasr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [mpfasr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [mpfasr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                     pready
);
  import mpfasr_pkg::*;

  // Only the first eight pins have lanes; the item fields are eight bits wide.
  localparam int unsigned LANES = (NUM_PINS < PIN_W) ? NUM_PINS : PIN_W;
  localparam int unsigned SUM_W = $clog2(LANES + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PIN_W-1:0]   active_levels_r;
  logic [COUNT_W-1:0] release_ticks_r;
  logic               report_en_r;
  logic               cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[CFG_IDX_W+1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_levels_r <= '0;
      release_ticks_r <= DEFAULT_RELEASE_TICKS;
      report_en_r     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ACTIVE_LEVELS: active_levels_r <= pwdata[PIN_W-1:0];
        REG_RELEASE_TICKS: release_ticks_r <= pwdata[COUNT_W-1:0];
        REG_REPORT_EN:     report_en_r     <= pwdata[0];
        default: ;  // unmapped: write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ACTIVE_LEVELS: prdata = CFG_DATA_W'(active_levels_r);
      REG_RELEASE_TICKS: prdata = CFG_DATA_W'(release_ticks_r);
      REG_REPORT_EN:     prdata = CFG_DATA_W'(report_en_r);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_op_r;
  logic [PIN_W-1:0] s1_levels_r;
  logic [PIN_W-1:0] s1_flagged_r;
  logic             in_acc;
  logic             s1_adv;     // input register item is processed this cycle
  logic             out_valid_r, out_valid_nxt;

  assign s1_adv   = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~s1_adv;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)      s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r      <= in_operation;
      s1_levels_r  <= in_pin_levels;
      s1_flagged_r <= in_event_pins;
    end
  end

  // ---------------------------------------------------------------------------
  // Pin state and per-pin update lanes
  // ---------------------------------------------------------------------------
  logic [LANES-1:0]   asserted_r, asserted_nxt;
  logic [COUNT_W-1:0] count_r   [LANES];
  logic [COUNT_W-1:0] count_nxt [LANES];
  lane_res_t          lane_res  [LANES];
  logic [LANES-1:0]   lane_upd;
  logic [LANES-1:0]   lane_mm;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mpfasr_lane u_lane (
      .operation     (s1_op_r),
      .level         (s1_levels_r[g]),
      .flagged       (s1_flagged_r[g]),
      .act_hi        (active_levels_r[g]),
      .asserted      (asserted_r[g]),
      .count         (count_r[g]),
      .release_ticks (release_ticks_r),
      .count_nxt     (count_nxt[g]),
      .res           (lane_res[g])
    );
    assign asserted_nxt[g] = lane_res[g].asserted;
    assign lane_upd[g]     = lane_res[g].upd;
    assign lane_mm[g]      = lane_res[g].mismatch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asserted_r <= '0;
      for (int i = 0; i < LANES; i++) begin
        count_r[i] <= '0;
      end
    end else if (s1_adv) begin
      asserted_r <= asserted_nxt;
      for (int i = 0; i < LANES; i++) begin
        count_r[i] <= count_nxt[i];
      end
    end
  end

  // Saturating mismatch total: one per inactive flagged pin
  logic [SUM_W-1:0] mm_inc;
  logic [MM_W:0]    mm_sum;
  logic [MM_W-1:0]  mm_total_r, mm_total_nxt;

  always_comb begin
    mm_inc = '0;
    for (int i = 0; i < LANES; i++) begin
      mm_inc = mm_inc + SUM_W'(lane_mm[i]);
    end
    mm_sum       = {1'b0, mm_total_r} + (MM_W + 1)'(mm_inc);
    mm_total_nxt = mm_sum[MM_W] ? MM_MAX : mm_sum[MM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_total_r <= '0;
    end else if (s1_adv) begin
      mm_total_r <= mm_total_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Reporting and output register
  // ---------------------------------------------------------------------------
  logic             first_done_r;
  logic             emit;
  logic [PIN_W-1:0] mask_nxt;
  logic [PIN_W-1:0] out_mask_r;
  logic [MM_W-1:0]  out_mm_r;

  // First item with reporting enabled after reset always reports, even with no pin change
  assign emit = s1_adv & report_en_r & ((|lane_upd) | ~first_done_r);

  // Asserted pin shows its active level, deasserted pin the inverse
  assign mask_nxt = PIN_W'(~(asserted_nxt ^ active_levels_r[LANES-1:0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_done_r <= 1'b0;
    end else if (s1_adv && report_en_r) begin
      first_done_r <= 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit)            out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_mask_r <= mask_nxt;
      out_mm_r   <= mm_total_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_level_mask     = out_mask_r;
  assign out_mismatch_count = out_mm_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // mismatch total only grows between resets
  a_mm_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> mm_total_r >= $past(mm_total_r))
    else $error("mismatch total decreased");

  // first report flag is set only while reporting is enabled
  a_first_needs_en: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(first_done_r) |-> $past(report_en_r))
    else $error("first report flag set with reporting disabled");

  // a tick never asserts a pin
  a_tick_no_assert: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_op_r == OP_TICK) |=> (asserted_r & ~$past(asserted_r)) == '0)
    else $error("pin asserted by a tick item");

  // an item must not be dropped while a result is waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !emit)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

// File: tb/pinmon_board_pkg.sv
`timescale 1ns / 1ps

package pinmon_board_pkg;

  import mpfasr_pkg::*;

  typedef struct {
    logic [PIN_W-1:0] level_mask;
    logic [MM_W-1:0]  mismatch_count;
  } pin_report_t;

  // Predicts the pin monitor and checks its level reports in order.
  class pin_report_board;
    logic [PIN_W-1:0]   act_lvl;
    logic [COUNT_W-1:0] rel_ticks;
    logic               rpt_en;
    logic [PIN_W-1:0]   asserted;
    logic [COUNT_W-1:0] inact_cnt [PIN_W];
    logic [MM_W-1:0]    mm_total;
    logic               first_done;
    pin_report_t        pending [$];
    int                 n_items;
    int                 n_reports;
    int                 n_errors;

    function new();
      act_lvl    = '0;
      rel_ticks  = DEFAULT_RELEASE_TICKS;
      rpt_en     = 1'b0;
      asserted   = '0;
      mm_total   = '0;
      first_done = 1'b0;
      foreach (inact_cnt[i]) inact_cnt[i] = '0;
      n_items    = 0;
      n_reports  = 0;
      n_errors   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_ACTIVE_LEVELS: act_lvl   = value[PIN_W-1:0];
        REG_RELEASE_TICKS: rel_ticks = value[COUNT_W-1:0];
        REG_REPORT_EN:     rpt_en    = value[0];
        default: ;
      endcase
    endfunction

    function void note_item(logic op, logic [PIN_W-1:0] lv, logic [PIN_W-1:0] ev);
      logic        changed;
      logic        is_act;
      pin_report_t r;
      changed = 1'b0;
      n_items++;
      for (int i = 0; i < PIN_W; i++) begin
        is_act = (lv[i] == act_lvl[i]);
        if (op == OP_TICK) begin
          if (asserted[i]) begin
            if (is_act) inact_cnt[i] = '0;
            else inact_cnt[i] = inact_cnt[i] + 1'b1;
            if (inact_cnt[i] == rel_ticks) begin
              asserted[i] = 1'b0;
              changed = 1'b1;
            end
          end
        end else if (ev[i]) begin
          if (is_act) begin
            inact_cnt[i] = '0;
            asserted[i] = 1'b1;
            changed = 1'b1;
          end else if (mm_total != MM_MAX) begin
            mm_total = mm_total + 1'b1;
          end
        end
      end
      if (!rpt_en) return;
      if (!first_done) begin
        first_done = 1'b1;
        changed = 1'b1;
      end
      if (!changed) return;
      r.level_mask     = ~(asserted ^ act_lvl);
      r.mismatch_count = mm_total;
      pending.push_back(r);
    endfunction

    function void check_report(logic [PIN_W-1:0] mask, logic [MM_W-1:0] mm);
      pin_report_t e;
      n_reports++;
      if (pending.size() == 0) begin
        $display("%0t ns: report with none expected, level_mask %02h mismatch_count %0d",
                 $time, mask, mm);
        n_errors++;
        return;
      end
      e = pending.pop_front();
      if (mask !== e.level_mask) begin
        $display("%0t ns: level_mask expected %02h actual %02h", $time, e.level_mask, mask);
        n_errors++;
      end
      if (mm !== e.mismatch_count) begin
        $display("%0t ns: mismatch_count expected %0d actual %0d",
                 $time, e.mismatch_count, mm);
        n_errors++;
      end
    endfunction

    function void check_leftovers();
      if (pending.size() != 0) begin
        $display("%0t ns: %0d expected reports never arrived", $time, pending.size());
        n_errors += pending.size();
      end
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import mpfasr_pkg::*;
  import pinmon_board_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Input channel
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_operation = OP_TICK;
  logic [PIN_W-1:0] in_pin_levels = '0;
  logic [PIN_W-1:0] in_event_pins = '0;

  // Report channel
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIN_W-1:0] out_level_mask;
  logic [MM_W-1:0]  out_mismatch_count;

  // Register port
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Percent chance per cycle that the sender idles / the receiver stalls
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  // Current "physical" pin levels; random items mostly keep them so that
  // asserted pins see runs of inactive ticks long enough to release.
  logic [PIN_W-1:0] cur_lv = '0;

  pin_report_board board = new();

  multi_pin_fast_assert_slow_release_top #(
    .NUM_PINS(8)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_pin_levels      (in_pin_levels),
    .in_event_pins      (in_event_pins),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_level_mask     (out_level_mask),
    .out_mismatch_count (out_mismatch_count),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #10 clk = ~clk;

  // Random receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Both monitors sample pre-edge values, so they see exactly what the DUT
  // saw at this edge. An item accepted now cannot produce a report at the
  // same edge, as the input and output registers lie between, so the order of the two calls is free.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        board.note_item(in_operation, in_pin_levels, in_event_pins);
      end
      if (out_valid && !out_stall) begin
        board.check_report(out_level_mask, out_mismatch_count);
      end
    end
  end

  // Backstop: the slowest legal run is well under a millisecond
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // Random idle gap, then hold the item until the DUT takes it.
  // in_valid gets one NBA per edge: the next item is driven at the edge that
  // accepted the previous one, or valid drops there for a gap.
  task automatic send_item(input logic op, input logic [PIN_W-1:0] lv,
                           input logic [PIN_W-1:0] ev);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_pin_levels <= lv;
    in_event_pins <= ev;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending, wait for every expected report, then let items that make
  // no report flush through the two pipeline stages.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Setup phase then access phase; pready is tied high so the write lands
  // at the end of the access phase.
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, value);
  endtask

  task automatic send_random();
    logic             op;
    logic [PIN_W-1:0] lv;
    logic [PIN_W-1:0] ev;
    op = 1'($urandom_range(1));
    // Mostly steady levels with the odd bit flip; sometimes a fresh pattern
    case ($urandom_range(9))
      0, 1, 2, 3, 4: lv = cur_lv;
      5, 6, 7:       lv = cur_lv ^ (8'h01 << $urandom_range(7));
      default:       lv = PIN_W'($urandom());
    endcase
    cur_lv = lv;
    // Sparse event masks dominate; all-zero and wide masks appear too
    case ($urandom_range(7))
      0:       ev = '0;
      1, 2:    ev = PIN_W'($urandom());
      default: ev = 8'h01 << $urandom_range(7);
    endcase
    send_item(op, lv, ev);
  endtask

  logic [PIN_W-1:0]   blk_act [8];
  logic [COUNT_W-1:0] blk_rel [8];
  logic               blk_rpt [8];

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed part ----
    // Reporting off after reset: state moves but nothing is reported.
    // Active levels all low: pins 4..7 assert, pins 0..3 each add a mismatch.
    send_item(OP_EVENT, 8'h0F, 8'hFF);
    send_item(OP_TICK, 8'hFF, 8'h00);
    drain();
    reg_write(REG_REPORT_EN, 1);
    send_item(OP_TICK, 8'h00, 8'h00);    // first item after enable: report
    send_item(OP_EVENT, 8'hAA, 8'h00);   // no flagged pin: nothing
    send_item(OP_EVENT, 8'h00, 8'h10);   // re-assert an asserted pin: report
    drain();
    reg_write(REG_RELEASE_TICKS, 2);
    send_item(OP_TICK, 8'hF0, 8'h00);
    send_item(OP_TICK, 8'hF0, 8'h00);    // second inactive tick releases 4..7
    send_item(OP_EVENT, 8'h01, 8'h03);   // one pin asserts, one mismatches
    send_item(OP_EVENT, 8'hFF, 8'hFF);   // every flagged pin inactive
    drain();
    reg_write(REG_ACTIVE_LEVELS, 32'hFF);
    reg_write(REG_RELEASE_TICKS, 1);
    send_item(OP_EVENT, 8'hFF, 8'hFF);   // all pins assert
    send_item(OP_TICK, 8'h7F, 8'h00);    // single inactive tick releases pin 7
    send_item(OP_EVENT, 8'h80, 8'h80);   // pin 7 back, stale count cleared
    drain();
    reg_write(REG_RELEASE_TICKS, 255);
    send_item(OP_TICK, 8'h00, 8'h00);
    send_item(OP_TICK, 8'h55, 8'h00);
    drain();
    // Toggle reporting: no second first-report on re-enable
    reg_write(REG_REPORT_EN, 0);
    send_item(OP_EVENT, 8'h00, 8'h0F);
    drain();
    reg_write(REG_REPORT_EN, 1);
    send_item(OP_TICK, 8'hFF, 8'h00);
    send_item(OP_EVENT, 8'h01, 8'h01);

    // Release setting of zero: counts wrap, release after 256 inactive ticks
    drain();
    reg_write(REG_RELEASE_TICKS, 0);
    send_item(OP_EVENT, 8'hFF, 8'hFF);
    repeat (256) send_item(OP_TICK, 8'h00, 8'h00);
    send_item(OP_TICK, 8'h00, 8'h00);

    // ---- Random part: eight register settings over four idle mixes ----
    blk_act = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h00, 8'h3C, 8'h00, 8'hC3};
    blk_rel = '{8'd1, 8'd255, 8'd3, 8'd2, 8'd4, 8'd4, 8'd6, 8'd5};
    blk_rpt = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
    blk_act[4] = PIN_W'($urandom());
    blk_act[6] = PIN_W'($urandom());
    blk_rel[4] = COUNT_W'($urandom_range(2, 8));
    for (int b = 0; b < 8; b++) begin
      drain();
      reg_write(REG_ACTIVE_LEVELS, CFG_DATA_W'(blk_act[b]));
      reg_write(REG_RELEASE_TICKS, CFG_DATA_W'(blk_rel[b]));
      reg_write(REG_REPORT_EN, CFG_DATA_W'(blk_rpt[b]));
      case (b / 2)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < 80; n++) begin
        // Mid-block the sender holds off until every report is back
        if (n == 40) drain();
        send_random();
      end
    end
    drain();

    board.check_leftovers();
    $display("covered %0d items and %0d level reports: directed corner cases,",
             board.n_items, board.n_reports);
    $display("count wrap, and eight register settings under four idle/stall mixes");
    if (board.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
